FILE: src/affine_matrix_builder_defines.svh
// Assertion macros used by the row serializer of the affine matrix builder.
`ifndef AFFINE_MATRIX_BUILDER_DEFINES_SVH
`define AFFINE_MATRIX_BUILDER_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define AMB_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked while out of reset.
`define AMB_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/amb_pkg.sv
// Shared types, constants and rounding helpers for the affine matrix builder.
package amb_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int CORDIC_ITERS  = 30;
   localparam int CW            = 33;

   typedef logic signed [CW-1:0] q30_type;
   typedef logic signed [31:0]   word_type;
   typedef logic [1:0]           row_type;

   localparam row_type ROW_FIRST = 2'd0;
   localparam row_type ROW_LAST  = 2'd3;

   typedef struct packed {
      q30_type c;
      q30_type s;
   } sincos_type;

   typedef struct packed {
      word_type x;
      word_type y;
      word_type z;
   } triple_type;

   typedef struct packed {
      triple_type r0;
      triple_type r1;
      triple_type r2;
      triple_type sh;
   } matrix_type;

   // Q60 sum back to Q30, half up.
   function automatic q30_type round_q30(input logic signed [67:0] v);
      logic signed [67:0] t;
      t = (v + 68'sd536870912) >>> 30;
      return t[CW-1:0];
   endfunction

   // Q30 * Qf product back to Qf, half up, clamped to 32 bits.
   function automatic word_type sat_round(input logic signed [67:0] v);
      logic signed [67:0] t;
      t = (v + 68'sd536870912) >>> 30;
      if (t > 68'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (t < -68'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return t[31:0];
      end
   endfunction

endpackage

FILE: src/amb_req_if.sv
// Request channel: scales, angles and shifts of one transform.
interface amb_req_if;
   logic                valid;
   logic                ready;
   logic signed [31:0]  scale_x;
   logic signed [31:0]  scale_y;
   logic signed [31:0]  scale_z;
   logic signed [18:0]  angle_x;
   logic signed [18:0]  angle_y;
   logic signed [18:0]  angle_z;
   logic signed [31:0]  shift_x;
   logic signed [31:0]  shift_y;
   logic signed [31:0]  shift_z;

   modport source(output valid, scale_x, scale_y, scale_z, angle_x, angle_y, angle_z,
                  shift_x, shift_y, shift_z, input ready);
   modport sink(input valid, scale_x, scale_y, scale_z, angle_x, angle_y, angle_z,
                shift_x, shift_y, shift_z, output ready);
endinterface

FILE: src/amb_rsp_if.sv
// Response channel: one matrix row per transfer.
interface amb_rsp_if;
   logic                valid;
   logic                ready;
   logic [1:0]          row_index;
   logic signed [31:0]  elem_c0;
   logic signed [31:0]  elem_c1;
   logic signed [31:0]  elem_c2;
   logic signed [31:0]  elem_c3;
   logic                last_row;

   modport source(output valid, row_index, elem_c0, elem_c1, elem_c2, elem_c3, last_row,
                  input ready);
   modport sink(input valid, row_index, elem_c0, elem_c1, elem_c2, elem_c3, last_row,
                output ready);
endinterface

FILE: src/affine_matrix_builder.sv
// Top level: affine matrix builder pipeline.
//
//   port       dir   handshake      carries
//   req_chan   in    valid/ready    scales, angles, shifts of one transform
//   rsp_chan   out   valid/ready    one matrix row with index and last flag
//
// From request to row 0 the path has 2 angle reduction stages, 30 CORDIC
// iterations, 1 sign fix, 6 matrix stages and 1 in the row holder.
// The sustained request rate is set by the row holder, which sends four rows per
// matrix; the pipeline itself advances every cycle while it is not held.
// When the holder is busy and the last matrix stage is full, all stages hold.
// Reset is synchronous and clears valid bits and the row holder only.
module affine_matrix_builder #(
   parameter int FRAC_BITS = amb_pkg::FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   amb_req_if.sink    req_chan,
   amb_rsp_if.source  rsp_chan
);
   import amb_pkg::*;

   localparam int SIDE_DEPTH = 2 + CORDIC_ITERS + 1;

   logic       en;
   logic       rot_valid, ser_ready;
   logic       cor_all_v;
   matrix_type rot_mat;

   logic                red_v  [0:2];
   q30_type             red_z  [0:2];
   logic                red_f  [0:2];
   logic                cor_v  [0:2];
   sincos_type          cor_sc [0:2];
   logic signed [18:0]  ang    [0:2];

   triple_type scale_in, shift_in, scale_d, shift_d;

   // Advance everything unless a finished matrix is waiting on the holder.
   assign en             = !rot_valid || ser_ready;
   assign req_chan.ready = en;

   assign ang[0] = req_chan.angle_x;
   assign ang[1] = req_chan.angle_y;
   assign ang[2] = req_chan.angle_z;

   assign scale_in = '{x: req_chan.scale_x, y: req_chan.scale_y, z: req_chan.scale_z};
   assign shift_in = '{x: req_chan.shift_x, y: req_chan.shift_y, z: req_chan.shift_z};

   // All three lanes advance together, so their valid bits always agree.
   assign cor_all_v = cor_v[0] & cor_v[1] & cor_v[2];

   for (genvar a = 0; a < 3; a++) begin : g_axis
      amb_angle_reduce #(.FRAC_BITS(FRAC_BITS)) u_reduce (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (req_chan.valid),
         .angle     (ang[a]),
         .out_valid (red_v[a]),
         .out_z     (red_z[a]),
         .out_flip  (red_f[a])
      );

      amb_cordic u_cordic (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (red_v[a]),
         .in_z      (red_z[a]),
         .in_flip   (red_f[a]),
         .out_valid (cor_v[a]),
         .out_sc    (cor_sc[a])
      );
   end

   amb_delay_line #(.WIDTH(2 * $bits(triple_type)), .DEPTH(SIDE_DEPTH)) u_side (
      .clock (clock),
      .en    (en),
      .din   ({scale_in, shift_in}),
      .dout  ({scale_d, shift_d})
   );

   amb_rotation u_rotation (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (cor_all_v),
      .in_x      (cor_sc[0]),
      .in_y      (cor_sc[1]),
      .in_z      (cor_sc[2]),
      .in_scale  (scale_d),
      .in_shift  (shift_d),
      .out_valid (rot_valid),
      .out_mat   (rot_mat)
   );

   amb_row_serializer #(.FRAC_BITS(FRAC_BITS)) u_rows (
      .clock    (clock),
      .reset    (reset),
      .in_valid (rot_valid),
      .in_ready (ser_ready),
      .in_mat   (rot_mat),
      .rsp      (rsp_chan)
   );
endmodule

FILE: src/amb_delay_line.sv
// Enabled shift register that keeps side data aligned with the pipeline.
module amb_delay_line #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);
   logic [WIDTH-1:0] tap_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];
endmodule

FILE: src/amb_angle_reduce.sv
// Two-stage angle reduction into [-pi/2, pi/2] with a flip flag.
module amb_angle_reduce #(
   parameter int FRAC_BITS = amb_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic signed [18:0]  angle,
   output logic                out_valid,
   output amb_pkg::q30_type    out_z,
   output logic                out_flip
);
   import amb_pkg::*;

   localparam int AW   = 49 - FRAC_BITS;
   localparam int KMAX = (FRAC_BITS < 15) ? 15 - FRAC_BITS : 0;
   localparam int MW   = 34 + KMAX;
   localparam logic [MW-1:0]      TWO_PI_U  = MW'(64'd6746518852);
   localparam logic signed [34:0] PI_S      = 35'sd3373259426;
   localparam logic signed [34:0] HALF_PI_S = 35'sd1686629713;
   localparam logic signed [34:0] TWO_PI_S  = 35'sd6746518852;

   logic signed [AW-1:0] a_wide;
   logic                 neg;
   logic [AW-1:0]        mag;
   logic [MW-1:0]        rem;
   logic signed [33:0]   red_in, red_ff;
   logic                 v1_ff;
   logic signed [34:0]   b;
   logic                 flip_in;
   q30_type              z_ff;
   logic                 flip_ff, v2_ff;

   // Stage 1: truncating remainder by 2*pi, one conditional subtract per bit.
   always_comb begin
      a_wide = $signed({{(AW-19){angle[18]}}, angle}) <<< (30 - FRAC_BITS);
      neg    = a_wide[AW-1];
      mag    = neg ? AW'(-a_wide) : AW'(a_wide);
      rem    = MW'(mag);
      for (int k = KMAX; k >= 0; k--) begin
         if (rem >= (TWO_PI_U << k)) begin
            rem = rem - (TWO_PI_U << k);
         end
      end
      red_in = neg ? -$signed({1'b0, rem[32:0]}) : $signed({1'b0, rem[32:0]});
   end

   // Stage 2: wrap into [-pi, pi], then fold the outer quarters.
   always_comb begin
      b       = 35'(red_ff);
      flip_in = 1'b0;
      if (b > PI_S) begin
         b = b - TWO_PI_S;
      end
      if (b < -PI_S) begin
         b = b + TWO_PI_S;
      end
      if (b > HALF_PI_S) begin
         b       = b - PI_S;
         flip_in = 1'b1;
      end else if (b < -HALF_PI_S) begin
         b       = b + PI_S;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         red_ff  <= red_in;
         z_ff    <= b[CW-1:0];
         flip_ff <= flip_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_z     = z_ff;
   assign out_flip  = flip_ff;
endmodule

FILE: src/amb_cordic.sv
// Rotation-mode CORDIC, one iteration per stage, plus a sign-fix stage.
module amb_cordic (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  amb_pkg::q30_type     in_z,
   input  logic                 in_flip,
   output logic                 out_valid,
   output amb_pkg::sincos_type  out_sc
);
   import amb_pkg::*;

   localparam q30_type GAIN = 33'sd652032874;

   function automatic q30_type atan_step(input int i);
      case (i)
         0:       return 33'sd843314856;
         1:       return 33'sd497837829;
         2:       return 33'sd263043836;
         3:       return 33'sd133525158;
         4:       return 33'sd67021686;
         5:       return 33'sd33543515;
         6:       return 33'sd16775850;
         7:       return 33'sd8388437;
         8:       return 33'sd4194282;
         9:       return 33'sd2097149;
         default: return q30_type'(1) <<< (30 - i);
      endcase
   endfunction

   q30_type    x_ff [0:CORDIC_ITERS-1];
   q30_type    y_ff [0:CORDIC_ITERS-1];
   q30_type    z_ff [0:CORDIC_ITERS-1];
   logic       f_ff [0:CORDIC_ITERS-1];
   logic       v_ff [0:CORDIC_ITERS-1];
   sincos_type sc_ff;
   logic       vo_ff;

   for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
      q30_type xi, yi, zi;
      logic    fi, vi;
      localparam q30_type STEP = atan_step(i);

      if (i == 0) begin : g_head
         assign xi = GAIN;
         assign yi = '0;
         assign zi = in_z;
         assign fi = in_flip;
         assign vi = in_valid;
      end else begin : g_body
         assign xi = x_ff[i-1];
         assign yi = y_ff[i-1];
         assign zi = z_ff[i-1];
         assign fi = f_ff[i-1];
         assign vi = v_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= vi;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            f_ff[i] <= fi;
            if (!zi[CW-1]) begin
               x_ff[i] <= xi - (yi >>> i);
               y_ff[i] <= yi + (xi >>> i);
               z_ff[i] <= zi - STEP;
            end else begin
               x_ff[i] <= xi + (yi >>> i);
               y_ff[i] <= yi - (xi >>> i);
               z_ff[i] <= zi + STEP;
            end
         end
      end
   end

   // Undo the half-turn fold.
   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (en) begin
         vo_ff <= v_ff[CORDIC_ITERS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sc_ff.c <= f_ff[CORDIC_ITERS-1] ? -x_ff[CORDIC_ITERS-1] : x_ff[CORDIC_ITERS-1];
         sc_ff.s <= f_ff[CORDIC_ITERS-1] ? -y_ff[CORDIC_ITERS-1] : y_ff[CORDIC_ITERS-1];
      end
   end

   assign out_valid = vo_ff;
   assign out_sc    = sc_ff;
endmodule

FILE: src/amb_rotation.sv
// Six-stage matrix path: Ry*Rz, Rx*(Ry*Rz), then per-row scaling.
module amb_rotation (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  amb_pkg::sincos_type  in_x,
   input  amb_pkg::sincos_type  in_y,
   input  amb_pkg::sincos_type  in_z,
   input  amb_pkg::triple_type  in_scale,
   input  amb_pkg::triple_type  in_shift,
   output logic                 out_valid,
   output amb_pkg::matrix_type  out_mat
);
   import amb_pkg::*;

   localparam int PW = 2 * CW;

   logic [5:0] v_ff;

   // Stage 1
   sincos_type         x1_ff, y1_ff, z1_ff;
   triple_type         sc1_ff, sh1_ff;
   logic signed [PW-1:0] p_cycz_ff, p_cysz_ff, p_sycz_ff, p_sysz_ff;
   // Stage 2
   sincos_type         x2_ff, y2_ff, z2_ff;
   triple_type         sc2_ff, sh2_ff;
   q30_type            yz00_ff, yz01_ff, yz20_ff, yz21_ff;
   // Stage 3
   triple_type         sc3_ff, sh3_ff;
   q30_type            r00_3_ff, r01_3_ff, r02_3_ff;
   logic signed [PW-1:0] m10a_ff, m10b_ff, m11a_ff, m11b_ff, m12_ff;
   logic signed [PW-1:0] m20a_ff, m20b_ff, m21a_ff, m21b_ff, m22_ff;
   // Stage 4
   triple_type         sc4_ff, sh4_ff;
   q30_type            r_ff [0:2][0:2];
   // Stage 5
   triple_type         sh5_ff;
   logic signed [CW+31:0] s_ff [0:2][0:2];
   // Stage 6
   matrix_type         mat_ff;

   logic signed [31:0] scl [0:2];

   assign scl[0] = sc4_ff.x;
   assign scl[1] = sc4_ff.y;
   assign scl[2] = sc4_ff.z;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // Stage 1: products of Ry*Rz
         x1_ff     <= in_x;
         y1_ff     <= in_y;
         z1_ff     <= in_z;
         sc1_ff    <= in_scale;
         sh1_ff    <= in_shift;
         p_cycz_ff <= in_y.c * in_z.c;
         p_cysz_ff <= in_y.c * in_z.s;
         p_sycz_ff <= in_y.s * in_z.c;
         p_sysz_ff <= in_y.s * in_z.s;

         // Stage 2: round Ry*Rz
         x2_ff   <= x1_ff;
         y2_ff   <= y1_ff;
         z2_ff   <= z1_ff;
         sc2_ff  <= sc1_ff;
         sh2_ff  <= sh1_ff;
         yz00_ff <= round_q30(68'(p_cycz_ff));
         yz01_ff <= round_q30(68'(p_cysz_ff));
         yz20_ff <= round_q30(68'(p_sycz_ff));
         yz21_ff <= round_q30(68'(p_sysz_ff));

         // Stage 3: products of Rx*(Ry*Rz); row 0 passes as is
         sc3_ff   <= sc2_ff;
         sh3_ff   <= sh2_ff;
         r00_3_ff <= yz00_ff;
         r01_3_ff <= yz01_ff;
         r02_3_ff <= -y2_ff.s;
         m10a_ff  <= x2_ff.c * z2_ff.s;
         m10b_ff  <= x2_ff.s * yz20_ff;
         m11a_ff  <= x2_ff.c * z2_ff.c;
         m11b_ff  <= x2_ff.s * yz21_ff;
         m12_ff   <= x2_ff.s * y2_ff.c;
         m20a_ff  <= x2_ff.s * z2_ff.s;
         m20b_ff  <= x2_ff.c * yz20_ff;
         m21a_ff  <= x2_ff.s * z2_ff.c;
         m21b_ff  <= x2_ff.c * yz21_ff;
         m22_ff   <= x2_ff.c * y2_ff.c;

         // Stage 4: exact sums, one rounding each
         sc4_ff     <= sc3_ff;
         sh4_ff     <= sh3_ff;
         r_ff[0][0] <= r00_3_ff;
         r_ff[0][1] <= r01_3_ff;
         r_ff[0][2] <= r02_3_ff;
         r_ff[1][0] <= round_q30(68'(m10b_ff) - 68'(m10a_ff));
         r_ff[1][1] <= round_q30(68'(m11a_ff) + 68'(m11b_ff));
         r_ff[1][2] <= round_q30(68'(m12_ff));
         r_ff[2][0] <= round_q30(68'(m20a_ff) + 68'(m20b_ff));
         r_ff[2][1] <= round_q30(68'(m21b_ff) - 68'(m21a_ff));
         r_ff[2][2] <= round_q30(68'(m22_ff));

         // Stage 5: scale each row
         sh5_ff <= sh4_ff;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               s_ff[i][j] <= r_ff[i][j] * scl[i];
            end
         end

         // Stage 6: round and clamp
         mat_ff.sh   <= sh5_ff;
         mat_ff.r0.x <= sat_round(68'(s_ff[0][0]));
         mat_ff.r0.y <= sat_round(68'(s_ff[0][1]));
         mat_ff.r0.z <= sat_round(68'(s_ff[0][2]));
         mat_ff.r1.x <= sat_round(68'(s_ff[1][0]));
         mat_ff.r1.y <= sat_round(68'(s_ff[1][1]));
         mat_ff.r1.z <= sat_round(68'(s_ff[1][2]));
         mat_ff.r2.x <= sat_round(68'(s_ff[2][0]));
         mat_ff.r2.y <= sat_round(68'(s_ff[2][1]));
         mat_ff.r2.z <= sat_round(68'(s_ff[2][2]));
      end
   end

   assign out_valid = v_ff[5];
   assign out_mat   = mat_ff;
endmodule

FILE: src/amb_row_serializer.sv
// Holds one finished matrix and sends it out as four row responses.
`include "affine_matrix_builder_defines.svh"

module amb_row_serializer #(
   parameter int FRAC_BITS = amb_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  amb_pkg::matrix_type  in_mat,
   amb_rsp_if.source            rsp
);
   import amb_pkg::*;

   localparam word_type ONE_Q = word_type'(64'd1 << FRAC_BITS);

   matrix_type mat_ff;
   row_type    row_ff;
   logic       full_ff;
   triple_type cur;
   logic       take;

   // Take a new matrix when empty or while the last row leaves.
   assign in_ready = !full_ff || (rsp.ready && row_ff == ROW_LAST);
   assign take     = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         row_ff  <= ROW_FIRST;
      end else if (take) begin
         full_ff <= 1'b1;
         row_ff  <= ROW_FIRST;
      end else if (full_ff && rsp.ready) begin
         if (row_ff == ROW_LAST) begin
            full_ff <= 1'b0;
         end else begin
            row_ff <= row_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         mat_ff <= in_mat;
      end
   end

   always_comb begin
      case (row_ff)
         2'd0:    cur = mat_ff.r0;
         2'd1:    cur = mat_ff.r1;
         2'd2:    cur = mat_ff.r2;
         default: cur = mat_ff.sh;
      endcase
   end

   assign rsp.valid     = full_ff;
   assign rsp.row_index = row_ff;
   assign rsp.elem_c0   = cur.x;
   assign rsp.elem_c1   = cur.y;
   assign rsp.elem_c2   = cur.z;
   assign rsp.elem_c3   = (row_ff == ROW_LAST) ? ONE_Q : '0;
   assign rsp.last_row  = (row_ff == ROW_LAST);

   `AMB_ASSERT_NXT(a_row_advance, clock, reset, full_ff && rsp.ready && row_ff != ROW_LAST, full_ff && row_ff == $past(row_ff) + 2'd1, "row did not advance")
   `AMB_ASSERT_NXT(a_drain, clock, reset, full_ff && rsp.ready && row_ff == ROW_LAST && !in_valid, !full_ff, "holder did not drain")
   `AMB_ASSERT_NXT(a_reload, clock, reset, take, full_ff && row_ff == ROW_FIRST, "new matrix not loaded at row zero")
   `AMB_ASSERT_IMP(a_hold_busy, clock, reset, full_ff && row_ff != ROW_LAST, !in_ready, "matrix overwritten mid-send")
endmodule

FILE: test/testbench.sv
// Self-checking testbench for the affine matrix builder: directed table, then random requests.
module testbench;
   import amb_pkg::*;

   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint TWO_PI_Q30  = 64'sd6746518852;
   localparam longint GAIN_Q30    = 64'sd652032874;
   localparam longint ONE_Q30     = 64'sd1073741824;
   localparam word_type ONE_QF    = 32'sh00010000;
   localparam int     RAND_ITEMS  = 315;

   typedef struct {
      word_type scl [3];
      logic signed [18:0] ang [3];
      word_type sh  [3];
   } xform_type;

   typedef struct {
      row_type  idx;
      word_type c0, c1, c2, c3;
      logic     last;
   } due_row_type;

   typedef struct {
      xform_type x;
      bit        zero_rows;   // scales all zero: rows 0-2 typed in as zero
   } vec_type;

   logic clock;
   logic reset;
   int   errors;
   int   snd_idle;
   int   rcv_idle;
   due_row_type rows_due [$];

   amb_req_if req_chan ();
   amb_rsp_if rsp_chan ();

   affine_matrix_builder DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic longint rnd30(longint v);
      return (v + 64'sd536870912) >>> 30;
   endfunction

   function automatic word_type clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return word_type'(v);
   endfunction

   task automatic sin_cos(input logic signed [18:0] ang, output longint c, output longint s);
      longint atan_lead [10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                                 33543515, 16775850, 8388437, 4194282, 2097149};
      longint a, x, y, z, t, step;
      bit flip;
      a = longint'(ang) * 64'sd16384;
      a = a % TWO_PI_Q30;
      if (a > PI_Q30) a -= TWO_PI_Q30;
      if (a < -PI_Q30) a += TWO_PI_Q30;
      flip = 0;
      // fold past a quarter turn, negate both outputs later
      if (a > HALF_PI_Q30) begin
         a -= PI_Q30;
         flip = 1;
      end else if (a < -HALF_PI_Q30) begin
         a += PI_Q30;
         flip = 1;
      end
      x = GAIN_Q30;
      y = 0;
      z = a;
      for (int i = 0; i < 30; i++) begin
         step = (i < 10) ? atan_lead[i] : (64'sd1 <<< (30 - i));
         if (z >= 0) begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            z -= step;
         end else begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            z += step;
         end
         x = t;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   task automatic predict_matrix(input xform_type x);
      longint cs [3], sn [3];
      longint rx [3][3], ry [3][3], rz [3][3], yz [3][3], r [3][3];
      longint acc;
      word_type e [3];
      due_row_type row;
      for (int i = 0; i < 3; i++) sin_cos(x.ang[i], cs[i], sn[i]);
      rx = '{'{ONE_Q30, 0, 0}, '{0, cs[0], sn[0]}, '{0, -sn[0], cs[0]}};
      ry = '{'{cs[1], 0, -sn[1]}, '{0, ONE_Q30, 0}, '{sn[1], 0, cs[1]}};
      rz = '{'{cs[2], sn[2], 0}, '{-sn[2], cs[2], 0}, '{0, 0, ONE_Q30}};
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += ry[i][k] * rz[k][j];
            yz[i][j] = rnd30(acc);
         end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += rx[i][k] * yz[k][j];
            r[i][j] = rnd30(acc);
         end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) e[j] = clamp32(rnd30(r[i][j] * longint'(x.scl[i])));
         row = '{row_type'(i), e[0], e[1], e[2], 32'sd0, 1'b0};
         rows_due.push_back(row);
      end
      row = '{ROW_LAST, x.sh[0], x.sh[1], x.sh[2], ONE_QF, 1'b1};
      rows_due.push_back(row);
   endtask

   task automatic send_xform(input xform_type x);
      req_chan.valid   <= 1'b1;
      req_chan.scale_x <= x.scl[0];
      req_chan.scale_y <= x.scl[1];
      req_chan.scale_z <= x.scl[2];
      req_chan.angle_x <= x.ang[0];
      req_chan.angle_y <= x.ang[1];
      req_chan.angle_z <= x.ang[2];
      req_chan.shift_x <= x.sh[0];
      req_chan.shift_y <= x.sh[1];
      req_chan.shift_z <= x.sh[2];
      do @(posedge clock); while (!req_chan.ready);
      if ($urandom_range(99) < snd_idle) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   function automatic word_type rand_word();
      case ($urandom_range(5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return word_type'($urandom);
         3: return word_type'($urandom_range(6, 0) - 3) <<< 16;
         default: return word_type'($signed($urandom_range(8 << 16)) - (4 << 16));
      endcase
   endfunction

   function automatic logic signed [18:0] rand_angle();
      if ($urandom_range(9) == 0) return 19'($urandom);
      return 19'($signed($urandom_range(2 * 205887)) - 205887);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rcv_idle);
      end
   end

   always @(posedge clock) begin
      due_row_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (rows_due.size() == 0) begin
            $error("row_index: no row expected, got %0d", rsp_chan.row_index);
            errors++;
         end else begin
            want = rows_due.pop_front();
            if (rsp_chan.row_index !== want.idx) begin
               $error("row_index: expected %0d, got %0d", want.idx, rsp_chan.row_index);
               errors++;
            end
            if (rsp_chan.elem_c0 !== want.c0) begin
               $error("elem_c0: expected %0d, got %0d", want.c0, rsp_chan.elem_c0);
               errors++;
            end
            if (rsp_chan.elem_c1 !== want.c1) begin
               $error("elem_c1: expected %0d, got %0d", want.c1, rsp_chan.elem_c1);
               errors++;
            end
            if (rsp_chan.elem_c2 !== want.c2) begin
               $error("elem_c2: expected %0d, got %0d", want.c2, rsp_chan.elem_c2);
               errors++;
            end
            if (rsp_chan.elem_c3 !== want.c3) begin
               $error("elem_c3: expected %0d, got %0d", want.c3, rsp_chan.elem_c3);
               errors++;
            end
            if (rsp_chan.last_row !== want.last) begin
               $error("last_row: expected %0b, got %0b", want.last, rsp_chan.last_row);
               errors++;
            end
         end
      end
   end

   initial begin
      vec_type     table_rows [$];
      xform_type   x;
      due_row_type row;
      int          wait_cyc;
      errors   = 0;
      snd_idle = 37;
      rcv_idle = 61;
      reset    = 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.scale_x <= '0;
      req_chan.scale_y <= '0;
      req_chan.scale_z <= '0;
      req_chan.angle_x <= '0;
      req_chan.angle_y <= '0;
      req_chan.angle_z <= '0;
      req_chan.shift_x <= '0;
      req_chan.shift_y <= '0;
      req_chan.shift_z <= '0;

      // scales, angles, shifts; zero_rows set where rows 0-2 must be all zero
      table_rows.push_back('{'{'{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}}, 1});
      table_rows.push_back('{'{'{0, 0, 0}, '{205887, -205887, 102944},
                              '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff}}, 1});
      table_rows.push_back('{'{'{0, 0, 0}, '{-262144, 262143, -1},
                              '{32'sh80000000, 32'sh7fffffff, -1}}, 1});
      table_rows.push_back('{'{'{65536, 65536, 65536}, '{0, 0, 0}, '{1, 2, 3}}, 0});
      table_rows.push_back('{'{'{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff},
                              '{0, 0, 0}, '{0, 0, 0}}, 0});
      table_rows.push_back('{'{'{32'sh80000000, 32'sh80000000, 32'sh80000000},
                              '{0, 0, 0}, '{0, 0, 0}}, 0});
      table_rows.push_back('{'{'{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff},
                              '{205887, -205887, 51472}, '{5, -5, 0}}, 0});
      table_rows.push_back('{'{'{65536, -65536, 131072},
                              '{102944, -102944, 102943}, '{0, 0, 0}}, 0});
      table_rows.push_back('{'{'{65536, 65536, 65536},
                              '{102945, -102945, 150000}, '{7, 8, 9}}, 0});
      table_rows.push_back('{'{'{65536, 65536, 65536},
                              '{262143, -262144, 230000}, '{0, 0, 0}}, 0});
      table_rows.push_back('{'{'{-65536, 32768, 1},
                              '{-205887, 205887, -150000}, '{-1, -1, -1}}, 0});
      table_rows.push_back('{'{'{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff},
                              '{25736, 25736, 25736}, '{0, 0, 0}}, 0});

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (table_rows[n]) begin
         x = table_rows[n].x;
         if (table_rows[n].zero_rows) begin
            for (int i = 0; i < 3; i++) begin
               row = '{row_type'(i), 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0};
               rows_due.push_back(row);
            end
            row = '{ROW_LAST, x.sh[0], x.sh[1], x.sh[2], ONE_QF, 1'b1};
            rows_due.push_back(row);
         end else begin
            predict_matrix(x);
         end
         send_xform(x);
      end

      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n == RAND_ITEMS / 3) begin
            snd_idle = 61;
            rcv_idle = 37;
         end else if (n == 2 * RAND_ITEMS / 3) begin
            snd_idle = 0;
            rcv_idle = 0;
         end
         for (int i = 0; i < 3; i++) begin
            x.scl[i] = rand_word();
            x.ang[i] = rand_angle();
            x.sh[i]  = word_type'($urandom);
         end
         predict_matrix(x);
         send_xform(x);
      end
      req_chan.valid <= 1'b0;

      wait_cyc = 0;
      while (rows_due.size() != 0 && wait_cyc < 20000) begin
         @(posedge clock);
         wait_cyc++;
      end
      repeat (60) @(posedge clock);
      if (rows_due.size() != 0) begin
         $error("row_index: %0d rows never arrived", rows_due.size());
         errors++;
      end
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
